@@ rtl/integer_to_ascii_formatter_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Implication checks, same cycle and next cycle, reset qualified.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define I2A_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define I2A_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, constants and the shift-add-3 step shared by the formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int NDIG   = 10;
    localparam int NSTG   = 6;
    localparam int DAB_PER = 8;

    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_LHEX = 2'd2;
    localparam logic [1:0] MODE_UHEX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    typedef struct packed {
        logic [4*NDIG-1:0] digs;
        logic [31:0]       bin;
        logic              neg;
        logic [1:0]        mode;
        logic [3:0]        nd;
    } item_t;

    function automatic item_t dabble8(input item_t it);
        item_t r;
        r = it;
        if (!it.mode[1]) begin
            for (int s = 0; s < DAB_PER; s++) begin
                for (int d = 0; d < NDIG; d++) begin
                    if (r.digs[4*d +: 4] >= 4'd5) begin
                        r.digs[4*d +: 4] = r.digs[4*d +: 4] + 4'd3;
                    end
                end
                {r.digs, r.bin} = {r.digs[4*NDIG-2:0], r.bin, 1'b0};
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/integer_to_ascii_formatter_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Prints a 32-bit word as signed/unsigned decimal or hex ASCII characters.
//
//   channel | ports                                   | direction
//   s_      | s_valid s_ready s_value s_mode          | in, one number
//   m_      | m_valid m_ready m_char_code m_last      | out, one character
//           | m_char_count                            |
//
// The first character passes every pipeline stage and the output register; a
// number then gives one character per cycle (1 to 11) while m_ready is high,
// set by the single character output register. The six-stage pipeline holds up
// to six numbers. Reset clears all valid bits; m_ready stalls hold full stages.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_value,
    input  logic [1:0]  s_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_char_code,
    output logic        m_last,
    output logic [3:0]  m_char_count
);
    import i2a_pkg::*;

    logic       p_valid;
    logic       p_ready;
    item_t      p_item;
    item_t      ser_reg;
    logic       ser_vld_reg;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    logic [3:0] total;
    logic [3:0] didx;
    logic [3:0] dig;

    i2a_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .in_mode   (s_mode),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .out_item  (p_item)
    );

    always_comb begin
        total    = ser_reg.nd + {3'd0, ser_reg.neg};
        m_last   = (pos_reg == total - 4'd1);
        didx     = ser_reg.nd - 4'd1 - (pos_reg - {3'd0, ser_reg.neg});
        dig      = ser_reg.digs[4*didx +: 4];
        if (ser_reg.neg && pos_reg == 4'd0) begin
            m_char_code = CH_MINUS;
        end else if (dig <= 4'd9) begin
            m_char_code = CH_ZERO + {4'd0, dig};
        end else if (ser_reg.mode == MODE_LHEX) begin
            m_char_code = CH_LA + {4'd0, dig} - 8'd10;
        end else begin
            m_char_code = CH_UA + {4'd0, dig} - 8'd10;
        end
        m_char_count = m_last ? total : 4'd0;
        m_valid      = ser_vld_reg;
        p_ready      = !ser_vld_reg || (m_ready && m_last);
        pos_next     = pos_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (p_ready) begin
            ser_reg <= p_item;
        end
        if (!aresetn) begin
            ser_vld_reg <= 1'b0;
            pos_reg     <= '0;
        end else if (p_ready) begin
            ser_vld_reg <= p_valid;
            pos_reg     <= '0;
        end else if (m_ready) begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ rtl/i2a_pipe.sv @@
// ----------------------------------------------------------------------------
// i2a_pipe
// Six-stage elastic pipeline: capture, four binary-to-BCD stages, digit count.
// ----------------------------------------------------------------------------
module i2a_pipe (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     in_value,
    input  logic [1:0]      in_mode,
    output logic            out_valid,
    input  logic            out_ready,
    output i2a_pkg::item_t  out_item
);
    import i2a_pkg::*;

    item_t             stg_reg [NSTG];
    item_t             stg_next [NSTG];
    logic [NSTG-1:0]   vld_reg;
    logic [NSTG:0]     rdy;
    item_t             cap;

    always_comb begin
        cap      = '0;
        cap.mode = in_mode;
        cap.neg  = (in_mode == MODE_SDEC) && in_value[31];
        if (in_mode[1]) begin
            cap.digs = {8'd0, in_value};
        end else begin
            cap.bin = cap.neg ? (32'd0 - in_value) : in_value;
        end
    end

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_comb begin
        stg_next[0] = cap;
        for (int i = 1; i < NSTG - 1; i++) begin
            stg_next[i] = dabble8(stg_reg[i-1]);
        end
        stg_next[NSTG-1]    = stg_reg[NSTG-2];
        stg_next[NSTG-1].nd = 4'd1;
        for (int d = 1; d < NDIG; d++) begin
            if (stg_reg[NSTG-2].digs[4*d +: 4] != 4'd0) begin
                stg_next[NSTG-1].nd = 4'(d + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (rdy[i]) begin
                stg_reg[i] <= stg_next[i];
            end
        end
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];
    assign out_item  = stg_reg[NSTG-1];

endmodule

@@ rtl/i2a_checker.sv @@
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks on the character stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_core_defines.svh"

module i2a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char_code,
    input logic       m_last,
    input logic [3:0] m_char_count
);
    `I2A_ASSERT_NOW(a_count_range, aclk, aresetn, m_valid && m_last, m_char_count >= 4'd1 && m_char_count <= 4'd11)
    `I2A_ASSERT_NOW(a_count_zero, aclk, aresetn, m_valid && !m_last, m_char_count == 4'd0)
    `I2A_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_char_code))
    `I2A_ASSERT_NEXT(a_no_gap, aclk, aresetn, m_valid && m_ready && !m_last, m_valid)
endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_char_code  (m_char_code),
    .m_last       (m_last),
    .m_char_count (m_char_count)
);
